// ===== rtl/core/hrhv_pkg.sv =====
// Types, string tables and reset constants for the HTTP request header validator.
package hrhv_pkg;

    localparam int NUM_NAMES  = 5;
    localparam int HOST_INDEX = 1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_UNKNOWN  = 2'd1;
    localparam logic [1:0] VERDICT_NO_HOST  = 2'd2;

    localparam logic [3:0] METHOD_LEN  = 4'd3;
    localparam logic [3:0] VERSION_LEN = 4'd8;

    localparam logic [7:0] METHOD_CHARS [4] = '{"G", "E", "T", 8'h00};
    localparam logic [7:0] VERSION_CHARS [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    localparam logic [7:0] NAME_CHARS [NUM_NAMES][16] = '{
        '{"U", "s", "e", "r", "-", "A", "g", "e", "n", "t",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "o", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "c", "c", "e", "p", "t", "-", "L", "a", "n",
          "g", "u", "a", "g", "e", 8'h00},
        '{"A", "c", "c", "e", "p", "t", "-", "E", "n", "c",
          "o", "d", "i", "n", "g", 8'h00},
        '{"C", "o", "n", "n", "e", "c", "t", "i", "o", "n",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd10, 4'd4, 4'd15, 4'd15, 4'd10};

    typedef struct packed {
        logic                 on_first_line;
        logic [1:0]           token_count;
        logic                 in_token;
        logic [3:0]           char_pos;
        logic                 pos_overflow;
        logic                 method_match;
        logic                 version_match;
        logic                 is_get;
        logic                 version_ok;
        logic [NUM_NAMES-1:0] name_mask;
        logic                 name_closed;
        logic                 line_empty;
        logic                 host_seen;
        logic                 header_failed;
        logic                 headers_done;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        on_first_line: 1'b1,
        token_count:   2'd0,
        in_token:      1'b0,
        char_pos:      4'd0,
        pos_overflow:  1'b0,
        method_match:  1'b1,
        version_match: 1'b1,
        is_get:        1'b0,
        version_ok:    1'b0,
        name_mask:     '1,
        name_closed:   1'b0,
        line_empty:    1'b1,
        host_seen:     1'b0,
        header_failed: 1'b0,
        headers_done:  1'b0
    };

endpackage

// ===== rtl/core/http_request_header_validator.sv =====
// Byte-serial HTTP GET request line and header name validator.
// A result transaction is registered, appearing in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless m_tready stalls a held output; the parse state
// and output register update in the cycle of acceptance, so byte compares set the cycle time.
// Reset: rst_n clears the parse state to the start of a request and empties the output.
// After each verdict the parse state returns to its reset values.
module http_request_header_validator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] req_byte
    input  logic        s_tlast,   // end_of_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] path_byte, [8] path_valid, [10:9] verdict, zero pad
    output logic        m_tuser    // is_verdict
);

    hrhv_pkg::parse_state_t state_reg;
    hrhv_pkg::parse_state_t state_next;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic [15:0] m_tdata_next;
    logic        m_tuser_reg;
    logic        m_tuser_next;

    logic        accept;
    logic        emit_path;
    logic        name_hit;
    logic        host_hit;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        logic [hrhv_pkg::NUM_NAMES-1:0] hits;
        hits = '0;
        for (int i = 0; i < hrhv_pkg::NUM_NAMES; i++)
        begin
            hits[i] = state_reg.name_mask[i] && !state_reg.pos_overflow
                      && (state_reg.char_pos == hrhv_pkg::NAME_LEN[i]);
        end
        name_hit = |hits;
        host_hit = hits[hrhv_pkg::HOST_INDEX];
    end

    always_comb
    begin
        hrhv_pkg::parse_state_t s;
        logic [7:0]             b;
        s         = state_reg;
        b         = s_tdata;
        emit_path = 1'b0;

        if (s.on_first_line)
        begin
            if (b == hrhv_pkg::CHAR_LF || b == hrhv_pkg::CHAR_SPACE)
            begin
                if (s.in_token)
                begin
                    if (s.token_count == 2'd1)
                    begin
                        s.is_get = s.method_match && s.char_pos == hrhv_pkg::METHOD_LEN
                                   && !s.pos_overflow;
                    end
                    else if (s.token_count == 2'd3 && s.version_match
                             && s.char_pos == hrhv_pkg::VERSION_LEN && !s.pos_overflow)
                    begin
                        s.version_ok = 1'b1;
                    end
                    s.in_token = 1'b0;
                end
                if (b == hrhv_pkg::CHAR_LF)
                begin
                    s.on_first_line = 1'b0;
                    s.char_pos      = '0;
                    s.pos_overflow  = 1'b0;
                    s.name_mask     = '1;
                    s.name_closed   = 1'b0;
                    s.line_empty    = 1'b1;
                end
            end
            else
            begin
                if (!s.in_token)
                begin
                    s.in_token     = 1'b1;
                    s.char_pos     = '0;
                    s.pos_overflow = 1'b0;
                    s.method_match = 1'b1;
                    if (s.token_count != 2'd3)
                    begin
                        s.token_count   = s.token_count + 2'd1;
                        s.version_match = 1'b1;
                    end
                    else
                    begin
                        s.version_match = 1'b0;
                    end
                end
                if (!s.pos_overflow)
                begin
                    if (s.token_count == 2'd1)
                    begin
                        s.method_match = s.method_match && s.char_pos < hrhv_pkg::METHOD_LEN
                                         && hrhv_pkg::METHOD_CHARS[s.char_pos[1:0]] == b;
                    end
                    else if (s.token_count == 2'd3)
                    begin
                        s.version_match = s.version_match
                                          && s.char_pos < hrhv_pkg::VERSION_LEN
                                          && hrhv_pkg::VERSION_CHARS[s.char_pos[2:0]] == b;
                    end
                end
                emit_path = (s.token_count == 2'd2) && s.is_get;
                if (s.char_pos == 4'd15)
                begin
                    s.pos_overflow = 1'b1;
                end
                s.char_pos = s.char_pos + 4'd1;
            end
        end
        else if (!s.headers_done && !s.header_failed)
        begin
            if (b == hrhv_pkg::CHAR_LF)
            begin
                if (s.line_empty)
                begin
                    s.headers_done = 1'b1;
                end
                else if (!s.name_closed)
                begin
                    s.header_failed = !name_hit;
                    s.host_seen     = s.host_seen || host_hit;
                end
                s.char_pos     = '0;
                s.pos_overflow = 1'b0;
                s.name_mask    = '1;
                s.name_closed  = 1'b0;
                s.line_empty   = 1'b1;
            end
            else if (b == hrhv_pkg::CHAR_COLON)
            begin
                if (!s.line_empty && !s.name_closed)
                begin
                    s.header_failed = !name_hit;
                    s.host_seen     = s.host_seen || host_hit;
                    s.name_closed   = 1'b1;
                end
            end
            else if (!s.name_closed)
            begin
                s.line_empty = 1'b0;
                for (int i = 0; i < hrhv_pkg::NUM_NAMES; i++)
                begin
                    if (s.pos_overflow || s.char_pos >= hrhv_pkg::NAME_LEN[i]
                        || hrhv_pkg::NAME_CHARS[i][s.char_pos] != b)
                    begin
                        s.name_mask[i] = 1'b0;
                    end
                end
                if (s.char_pos == 4'd15)
                begin
                    s.pos_overflow = 1'b1;
                end
                s.char_pos = s.char_pos + 4'd1;
            end
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        state_next    = state_reg;

        if (s_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = s;
            if (s_tlast)
            begin
                m_tvalid_next     = 1'b1;
                m_tuser_next      = 1'b1;
                m_tdata_next      = '0;
                m_tdata_next[8]   = s.is_get && s.version_ok && !s.on_first_line;
                m_tdata_next[10:9] = s.header_failed ? hrhv_pkg::VERDICT_UNKNOWN
                                   : (s.host_seen ? hrhv_pkg::VERDICT_ACCEPTED
                                                  : hrhv_pkg::VERDICT_NO_HOST);
                state_next        = hrhv_pkg::STATE_RESET;
            end
            else if (emit_path)
            begin
                m_tvalid_next     = 1'b1;
                m_tuser_next      = 1'b0;
                m_tdata_next      = '0;
                m_tdata_next[7:0] = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hrhv_pkg::STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
